/* rtl/core/ifr_pkg.sv */
package ifr_pkg;

  // Framing bytes
  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ADDR_BYTE  = 8'h03;
  localparam logic [7:0] CTRL_SEQ0  = 8'h00;
  localparam logic [7:0] CTRL_SEQ1  = 8'h40;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_FLAG   = 8'h5E;
  localparam logic [7:0] ESC_ESC    = 8'h5D;

  // Reply control bytes
  localparam logic [7:0] REPLY_RR0  = 8'h05;
  localparam logic [7:0] REPLY_RR1  = 8'h85;
  localparam logic [7:0] REPLY_REJ0 = 8'h01;
  localparam logic [7:0] REPLY_REJ1 = 8'h81;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_BADCHK  = 2'd2;
  localparam logic [1:0] KIND_DUP     = 2'd3;

  localparam int unsigned LEN_OUT_W = 16;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           data;
    logic [LEN_OUT_W-1:0] len;
  } result_t;

endpackage

/* rtl/core/ifr_if.sv */
// Input byte channel
interface ifr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel
interface ifr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [15:0] payload_length;

  modport source (output valid, output out_kind, output out_byte,
                  output payload_length, input ready);
  modport sink   (input valid, input out_kind, input out_byte,
                  input payload_length, output ready);
endinterface

/* rtl/core/info_frame_receiver_with_ack_unit.sv */
// Stop-and-wait information frame receiver. Raw line bytes come in on in_ch,
// one per transfer; the unit finds the header (flag, address, control with
// the sequence bit, header check), removes escape stuffing and passes the
// payload out on out_ch one byte late (a duplicate's payload is withheld), so
// the trailing XOR check byte is never shown as payload. On the closing flag
// it gives one verdict (accepted, bad check or duplicate) with the reply control
// byte and the saturated payload length. One byte is taken every cycle as long
// as out_ch keeps up: the byte sits in an input register, the whole frame state
// updates in a single pass, and any result lands in the output register when
// the byte leaves the input register, which waits while out_ch holds back.
// Throughput is bounded only by out_ch backpressure.
module info_frame_receiver_with_ack_unit #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ifr_in_if.sink    in_ch,
  ifr_out_if.source out_ch
);

  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

  // Receive phase codes
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_FLAG = 3'd1;
  localparam logic [2:0] PH_ADDR = 3'd2;
  localparam logic [2:0] PH_CTRL = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_ESC  = 3'd5;

  // Input register
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_adv;

  // Frame state
  logic [2:0]             phase_r, phase_nxt;
  logic                   fseq_r, fseq_nxt;
  logic                   eseq_r, eseq_nxt;
  logic [7:0]             xor_r, xor_nxt;
  logic [7:0]             held_r, held_nxt;
  logic                   held_vld_r, held_vld_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;

  // Output register
  logic                out_vld_r;
  ifr_pkg::result_t    res_r, res_nxt;
  logic                emit;

  // Per-byte work
  logic        take;
  logic [7:0]  take_data;
  logic        clear;
  logic [31:0] cnt_ext;
  logic [15:0] len_sat;

  assign s1_adv      = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || s1_adv;

  assign cnt_ext = 32'(cnt_r);
  assign len_sat = (cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : cnt_ext[15:0];

  // Next-state and result for the byte in the input register
  always_comb begin
    phase_nxt    = phase_r;
    fseq_nxt     = fseq_r;
    eseq_nxt     = eseq_r;
    xor_nxt      = xor_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    cnt_nxt      = cnt_r;
    emit         = 1'b0;
    res_nxt      = '0;
    take         = 1'b0;
    take_data    = s1_byte_r;
    clear        = 1'b0;

    case (phase_r)
      PH_FLAG: begin
        if (s1_byte_r == ifr_pkg::ADDR_BYTE) begin
          phase_nxt = PH_ADDR;
        end else if (s1_byte_r == ifr_pkg::FLAG_BYTE) begin
          phase_nxt = PH_FLAG;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_ADDR: begin
        if (s1_byte_r == ifr_pkg::CTRL_SEQ0 || s1_byte_r == ifr_pkg::CTRL_SEQ1) begin
          fseq_nxt  = (s1_byte_r == ifr_pkg::CTRL_SEQ1);
          phase_nxt = PH_CTRL;
        end else if (s1_byte_r == ifr_pkg::FLAG_BYTE) begin
          phase_nxt = PH_FLAG;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_CTRL: begin
        // header check is address XOR control
        if (s1_byte_r == (ifr_pkg::ADDR_BYTE ^
                          (fseq_r ? ifr_pkg::CTRL_SEQ1 : ifr_pkg::CTRL_SEQ0))) begin
          clear     = 1'b1;
          phase_nxt = PH_DATA;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (s1_byte_r == ifr_pkg::FLAG_BYTE) begin
          // closing flag: verdict
          emit        = 1'b1;
          res_nxt.len = len_sat;
          if (fseq_r != eseq_r) begin
            res_nxt.kind = ifr_pkg::KIND_DUP;
            res_nxt.data = eseq_r ? ifr_pkg::REPLY_REJ1 : ifr_pkg::REPLY_REJ0;
          end else if (held_vld_r && xor_r == held_r) begin
            res_nxt.kind = ifr_pkg::KIND_ACCEPT;
            res_nxt.data = fseq_r ? ifr_pkg::REPLY_RR0 : ifr_pkg::REPLY_RR1;
            eseq_nxt     = ~eseq_r;
          end else begin
            res_nxt.kind = ifr_pkg::KIND_BADCHK;
            res_nxt.data = fseq_r ? ifr_pkg::REPLY_REJ1 : ifr_pkg::REPLY_REJ0;
          end
          phase_nxt = PH_HUNT;
          clear     = 1'b1;
        end else if (s1_byte_r == ifr_pkg::ESC_BYTE) begin
          phase_nxt = PH_ESC;
        end else begin
          take = 1'b1;
        end
      end
      PH_ESC: begin
        phase_nxt = PH_DATA;
        if (s1_byte_r == ifr_pkg::ESC_FLAG) begin
          take      = 1'b1;
          take_data = ifr_pkg::FLAG_BYTE;
        end else if (s1_byte_r == ifr_pkg::ESC_ESC) begin
          take      = 1'b1;
          take_data = ifr_pkg::ESC_BYTE;
        end
      end
      default: begin
        phase_nxt = (s1_byte_r == ifr_pkg::FLAG_BYTE) ? PH_FLAG : PH_HUNT;
      end
    endcase

    if (clear) begin
      xor_nxt      = '0;
      held_nxt     = '0;
      held_vld_nxt = 1'b0;
      cnt_nxt      = '0;
    end

    // release the held byte, hold the new one
    if (take) begin
      if (held_vld_r) begin
        if (fseq_r == eseq_r) begin
          emit         = 1'b1;
          res_nxt.kind = ifr_pkg::KIND_PAYLOAD;
          res_nxt.data = held_r;
          res_nxt.len  = '0;
        end
        xor_nxt = xor_r ^ held_r;
        if (cnt_r != COUNT_MAX) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      held_nxt     = take_data;
      held_vld_nxt = 1'b1;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  // Frame state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      fseq_r     <= 1'b0;
      eseq_r     <= 1'b0;
      xor_r      <= '0;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      cnt_r      <= '0;
    end else if (s1_adv) begin
      phase_r    <= phase_nxt;
      fseq_r     <= fseq_nxt;
      eseq_r     <= eseq_nxt;
      xor_r      <= xor_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.out_kind       = res_r.kind;
  assign out_ch.out_byte       = res_r.data;
  assign out_ch.payload_length = res_r.len;

`ifndef ASSERT_OFF
  // payload transfers carry no length
  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.kind == ifr_pkg::KIND_PAYLOAD |-> res_r.len == '0)
    else $error("payload result with nonzero length");

  // the count only moves once a byte is held
  a_cnt_held: assert property (@(posedge clk) disable iff (!rst_n)
    !held_vld_r |-> cnt_r == '0)
    else $error("byte count nonzero with no held byte");

  // any verdict returns to hunting
  a_verdict_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && emit && res_nxt.kind != ifr_pkg::KIND_PAYLOAD |=> phase_r == PH_HUNT)
    else $error("verdict did not return to hunting");

  // an accepted frame flips the expected sequence bit
  a_accept_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && emit && res_nxt.kind == ifr_pkg::KIND_ACCEPT |=> eseq_r != $past(eseq_r))
    else $error("expected sequence not toggled on accept");
`endif

endmodule
